// ===== design/efs_pkg.sv =====
// ----------------------------------------------------------------------------
// efs_pkg
// Shared constants for the even value filter and sorter.
// ----------------------------------------------------------------------------
package efs_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 8;

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int TUSER_W = 2;

   // Bit positions inside the result tuser.
   localparam int TUSER_OVERFLOWED = 0;
   localparam int TUSER_EMPTY      = 1;

endpackage

// ===== design/efs_ram.sv =====
// ----------------------------------------------------------------------------
// efs_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module efs_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/even_filter_sorter_core.sv =====
// ----------------------------------------------------------------------------
// even_filter_sorter_core
// Keeps the even values of a frame in a RAM, sorted by insertion, and emits
// them in ascending order after the last item of the frame.
// ----------------------------------------------------------------------------
//  Channel  Direction  Item contents
//  req_     in         tdata: value; tlast: frame_end
//  rsp_     out        tdata: sorted_value; tlast: run_end;
//                      tuser: overflowed, empty_res
//
// An odd or dropped item, or the first kept item of a frame, is handled in ST_IDLE alone.
// Any other kept item walks through ST_INSERT, which shifts one RAM entry per
// cycle for every stored value above it, then writes the value in its place.
// After the last item, each result takes a RAM read, then a load of the output
// register, which waits while the register is full and rsp_tready is low.
// The synchronous reset clears the count and the drop flag; the RAM needs no
// clearing. The last result waits in the output register while a new frame
// is already being taken.
// ----------------------------------------------------------------------------
module even_filter_sorter_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [efs_pkg::TDATA_W-1:0] req_tdata,   // value
   input  logic                        req_tlast,   // frame_end
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [efs_pkg::TDATA_W-1:0] rsp_tdata,   // sorted_value
   output logic                        rsp_tlast,   // run_end
   output logic [efs_pkg::TUSER_W-1:0] rsp_tuser    // overflowed, empty_res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_PLACE,
      ST_EMIT_READ,
      ST_EMIT_LOAD
   } state_type;

   state_type                       state_ff, state_in;
   logic [efs_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            drop_ff, drop_in;
   logic                            last_ff, last_in;
   logic [efs_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [efs_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [efs_pkg::DATA_WIDTH-1:0]  val_ff, val_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [efs_pkg::DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [efs_pkg::TUSER_W-1:0]     rsp_user_ff, rsp_user_in;

   logic                            wr_en;
   logic [efs_pkg::IDX_W-1:0]       wr_addr;
   logic [efs_pkg::DATA_WIDTH-1:0]  wr_data;
   logic [efs_pkg::IDX_W-1:0]       rd_addr;
   logic [efs_pkg::DATA_WIDTH-1:0]  rd_data;

   logic [efs_pkg::DATA_WIDTH-1:0]  req_value;
   logic                            req_accept;
   logic                            slot_free;
   state_type                       done_state;

   efs_ram #(
      .DEPTH (efs_pkg::CAPACITY),
      .WIDTH (efs_pkg::DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_value  = req_tdata[efs_pkg::DATA_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign done_state = last_ff ? ST_EMIT_READ : ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = val_ff;
      rd_addr      = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = efs_pkg::IDX_W'(count_ff - efs_pkg::CNT_W'(1));
            if (req_accept) begin
               last_in = req_tlast;
               val_in  = req_value;
               pos_in  = efs_pkg::IDX_W'(count_ff);
               idx_in  = '0;
               if (req_value[0] == 1'b0 &&
                   count_ff == efs_pkg::CNT_W'(efs_pkg::CAPACITY)) begin
                  drop_in  = 1'b1;
                  state_in = req_tlast ? ST_EMIT_READ : ST_IDLE;
               end else if (req_value[0] == 1'b0 && count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = req_value;
                  count_in = count_ff + efs_pkg::CNT_W'(1);
                  state_in = req_tlast ? ST_EMIT_READ : ST_IDLE;
               end else if (req_value[0] == 1'b0) begin
                  state_in = ST_INSERT;
               end else begin
                  state_in = req_tlast ? ST_EMIT_READ : ST_IDLE;
               end
            end
         end

         ST_INSERT: begin
            rd_addr = pos_ff - efs_pkg::IDX_W'(1) - efs_pkg::IDX_W'(1);
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (rd_data > val_ff) begin
               wr_data = rd_data;
               pos_in  = pos_ff - efs_pkg::IDX_W'(1);
               if (pos_ff == efs_pkg::IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_data  = val_ff;
               count_in = count_ff + efs_pkg::CNT_W'(1);
               state_in = done_state;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = val_ff;
            count_in = count_ff + efs_pkg::CNT_W'(1);
            state_in = done_state;
         end

         ST_EMIT_READ: begin
            if (count_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_user_in  = '0;
                  rsp_user_in[efs_pkg::TUSER_OVERFLOWED] = drop_ff;
                  rsp_user_in[efs_pkg::TUSER_EMPTY]      = 1'b1;
                  drop_in      = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_EMIT_LOAD;
            end
         end

         ST_EMIT_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               rsp_user_in  = '0;
               rsp_user_in[efs_pkg::TUSER_OVERFLOWED] = drop_ff;
               if (efs_pkg::CNT_W'(idx_ff) + efs_pkg::CNT_W'(1) == count_ff) begin
                  rsp_last_in = 1'b1;
                  count_in    = '0;
                  drop_in     = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  idx_in      = idx_ff + efs_pkg::IDX_W'(1);
                  state_in    = ST_EMIT_READ;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = efs_pkg::TDATA_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
